// ===== design/elo_pkg.sv =====
// ----------------------------------------------------------------------------
// ECG lead-off classifier package
// Shared widths, electrode slots, window thresholds and helper types.
// ----------------------------------------------------------------------------
package elo_pkg;

  localparam int unsigned READING_BITS = 12;
  localparam int unsigned READING_W    = 12;
  localparam int unsigned CHANNEL_W    = 3;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned NUM_SLOTS    = 5;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [SLOT_W-1:0] SLOT_RA = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_RL = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_LA = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LL = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_V1 = 3'd4;

  localparam logic [4:0] BIT_LA  = 5'h01;
  localparam logic [4:0] BIT_RA  = 5'h02;
  localparam logic [4:0] BIT_LL  = 5'h04;
  localparam logic [4:0] BIT_RL  = 5'h08;
  localparam logic [4:0] BIT_V1  = 5'h10;
  localparam logic [4:0] ALL_OFF = 5'h1F;

  localparam int unsigned OFF_LO        = 562;
  localparam int unsigned OFF_HI        = 843;
  localparam int unsigned FIVE_DRV_OFF  = 1724;
  localparam int unsigned FIVE_ON_A_LO  = 1549;
  localparam int unsigned FIVE_ON_A_HI  = 1712;
  localparam int unsigned FIVE_ON_B_LO  = 1138;
  localparam int unsigned FIVE_ON_B_HI  = 1408;
  localparam int unsigned FIVE_LOW_HI   = 1094;
  localparam int unsigned THREE_DRV_OFF = 1523;
  localparam int unsigned THREE_ON_LO   = 1211;
  localparam int unsigned THREE_ON_HI   = 1480;
  localparam int unsigned THREE_LOW_HI  = 1146;

  localparam logic [PADDR_W-1:0] ADDR_LEAD_MODE = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIVE      = 2'd0,
    MODE_THREE_I   = 2'd1,
    MODE_THREE_II  = 2'd2,
    MODE_THREE_III = 2'd3
  } lead_mode_e;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_EVAL  = 1'b1
  } item_kind_e;

  typedef logic [READING_BITS-1:0] reading_t;
  typedef reading_t [NUM_SLOTS-1:0] reading_arr_t;

  typedef struct packed {
    logic [4:0] mask;
    logic       held;
  } eval_res_t;

  // Maps a vector indexed by slot number onto the off mask bit order.
  function automatic logic [4:0] slot_to_mask(input logic [NUM_SLOTS-1:0] s);
    slot_to_mask = {s[SLOT_V1], s[SLOT_RL], s[SLOT_LL], s[SLOT_RA], s[SLOT_LA]};
  endfunction

endpackage

// ===== design/elo_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ECG lead-off classifier configuration registers
// APB-style register file holding the lead mode.
// ----------------------------------------------------------------------------
module elo_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [elo_pkg::PADDR_W-1:0]  paddr,
  input  logic [elo_pkg::PDATA_W-1:0]  pwdata,
  output logic [elo_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output elo_pkg::lead_mode_e          lead_mode_o
);
  import elo_pkg::*;

  lead_mode_e lead_mode_q;
  logic       hit;
  logic       wr_en;

  assign pready = 1'b1;
  // Decode on the word address so that unaligned bytes map to the same word.
  assign hit    = (paddr[PADDR_W-1:2] == ADDR_LEAD_MODE[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_mode_q <= MODE_FIVE;
    end else if (wr_en) begin
      lead_mode_q <= lead_mode_e'(pwdata[MODE_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = PDATA_W'(lead_mode_q);
    end
  end

  assign lead_mode_o = lead_mode_q;

endmodule

// ===== design/elo_eval.sv =====
// ----------------------------------------------------------------------------
// ECG lead-off classifier evaluation logic
// Window classification of the five stored readings for the active mode.
// ----------------------------------------------------------------------------
module elo_eval (
  input  elo_pkg::reading_arr_t  readings_i,
  input  elo_pkg::lead_mode_e    lead_mode_i,
  input  logic [4:0]             last_mask_i,
  output elo_pkg::eval_res_t     res_o
);
  import elo_pkg::*;

  logic [NUM_SLOTS-1:0] off_v;
  logic [4:0]           off_m;
  reading_t             rl;
  reading_t             v1;
  reading_t             r;
  logic [SLOT_W-1:0]    ref_slot;
  logic [NUM_SLOTS-1:0] ref_onehot;
  logic [4:0]           pair;
  logic [4:0]           five_m;
  logic                 five_hit;
  logic [4:0]           three_m;
  logic                 three_hit;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      off_v[s] = (readings_i[s] > OFF_LO) && (readings_i[s] < OFF_HI);
    end
  end

  assign off_m = slot_to_mask(off_v);
  assign rl    = readings_i[SLOT_RL];
  assign v1    = readings_i[SLOT_V1];

  always_comb begin
    five_hit = 1'b1;
    five_m   = '0;
    if (rl > FIVE_DRV_OFF) begin
      five_m = (v1 > FIVE_DRV_OFF) ? (BIT_LA | BIT_RA | BIT_LL) : ALL_OFF;
    end else if (((rl > FIVE_ON_A_LO) && (rl < FIVE_ON_A_HI)) ||
                 ((rl > FIVE_ON_B_LO) && (rl < FIVE_ON_B_HI))) begin
      five_m = off_m & (BIT_LA | BIT_RA | BIT_LL | BIT_V1);
    end else if (rl < FIVE_LOW_HI) begin
      five_m = off_m & BIT_V1;
    end else begin
      five_hit = 1'b0;
    end
  end

  always_comb begin
    case (lead_mode_i)
      MODE_THREE_I:  ref_slot = SLOT_LL;
      MODE_THREE_II: ref_slot = SLOT_LA;
      default:       ref_slot = SLOT_RA;
    endcase
  end

  always_comb begin
    case (lead_mode_i)
      MODE_THREE_I:  r = readings_i[SLOT_LL];
      MODE_THREE_II: r = readings_i[SLOT_LA];
      default:       r = readings_i[SLOT_RA];
    endcase
  end

  assign ref_onehot = NUM_SLOTS'(1) << ref_slot;
  assign pair       = (BIT_LA | BIT_RA | BIT_LL) & ~slot_to_mask(ref_onehot);

  always_comb begin
    three_hit = 1'b1;
    three_m   = '0;
    if (r > THREE_DRV_OFF) begin
      if ((rl < THREE_DRV_OFF) && (v1 > THREE_DRV_OFF)) begin
        three_m = pair | BIT_RL;
      end else if ((v1 < THREE_DRV_OFF) && (rl > THREE_DRV_OFF)) begin
        three_m = pair | BIT_V1;
      end else if ((v1 > THREE_DRV_OFF) && (rl > THREE_DRV_OFF)) begin
        three_m = pair;
      end else begin
        three_m = ALL_OFF;
      end
    end else if ((r > THREE_ON_LO) && (r < THREE_ON_HI)) begin
      three_m = off_m & ~slot_to_mask(ref_onehot);
    end else if (r < THREE_LOW_HI) begin
      three_m = off_m & (BIT_RL | BIT_V1);
    end else begin
      three_hit = 1'b0;
    end
  end

  always_comb begin
    if (lead_mode_i == MODE_FIVE) begin
      res_o.mask = five_hit ? five_m : last_mask_i;
      res_o.held = !five_hit;
    end else begin
      res_o.mask = three_hit ? three_m : last_mask_i;
      res_o.held = !three_hit;
    end
  end

endmodule

// ===== design/ecg_lead_off_classifier.sv =====
// ----------------------------------------------------------------------------
// ECG lead-off classifier
// Stores per-electrode lead-off readings and classifies them into an off mask.
// ----------------------------------------------------------------------------
// Each request on the input channel either stores a reading for one electrode
// or evaluates the stored readings; every request yields exactly one result
// on the output channel carrying off_mask, bad_channel and held.
// A request is taken into an input register, classified combinationally and
// written to the output register when it advances, which an output stall can
// delay. One request is accepted every cycle while the output is not stalled;
// the rate is set by the single classify stage between the two registers.
// The lead mode is to be written through the APB-style port only while the
// block is idle; the block itself does not enforce this. When the receiver
// stalls, the pending result holds and one further request is still accepted
// into the input register before in_stall_o rises. Reset clears all readings,
// the last mask and the lead mode to five-lead.
// ----------------------------------------------------------------------------
module ecg_lead_off_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [elo_pkg::PADDR_W-1:0]          paddr,
  input  logic [elo_pkg::PDATA_W-1:0]          pwdata,
  output logic [elo_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [elo_pkg::CHANNEL_W-1:0]        channel_i,
  input  logic [elo_pkg::READING_W-1:0]        reading_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [4:0]                           off_mask_o,
  output logic                                 bad_channel_o,
  output logic                                 held_o
);
  import elo_pkg::*;

  lead_mode_e              lead_mode;
  logic                    in_valid_q;
  item_kind_e              kind_q;
  logic [CHANNEL_W-1:0]    channel_q;
  reading_t                reading_q;
  reading_arr_t            readings_q;
  logic [4:0]              last_mask_q;
  logic                    out_valid_q;
  logic [4:0]              off_mask_q;
  logic                    bad_q;
  logic                    held_q;
  logic                    advance;
  logic                    store_ok;
  eval_res_t               res;

  elo_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .lead_mode_o (lead_mode)
  );

  elo_eval u_eval (
    .readings_i  (readings_q),
    .lead_mode_i (lead_mode),
    .last_mask_i (last_mask_q),
    .res_o       (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign store_ok   = (channel_q < NUM_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      kind_q    <= item_kind_e'(kind_i);
      channel_q <= channel_i;
      reading_q <= READING_BITS'(reading_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readings_q  <= '0;
      last_mask_q <= '0;
    end else if (advance) begin
      if (kind_q == KIND_STORE) begin
        if (store_ok) begin
          readings_q[channel_q[SLOT_W-1:0]] <= reading_q;
        end
      end else begin
        last_mask_q <= res.mask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (kind_q == KIND_STORE) begin
        off_mask_q <= last_mask_q;
        bad_q      <= !store_ok;
        held_q     <= 1'b0;
      end else begin
        off_mask_q <= res.mask;
        bad_q      <= 1'b0;
        held_q     <= res.held;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign off_mask_o    = off_mask_q;
  assign bad_channel_o = bad_q;
  assign held_o        = held_q;

endmodule
